FILE: design/usbcep_pkg.sv
`timescale 1ns / 1ps

package usbcep_pkg;

   // Event kinds carried in the request tuser
   typedef enum logic [2:0] {
      CMD_SETUP   = 3'd0,
      CMD_IN_DONE = 3'd1,
      CMD_BUS_RST = 3'd2,
      CMD_SUSPEND = 3'd3,
      CMD_WAKEUP  = 3'd4
   } cmd_type;

   // Result action codes
   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_SEND_IN  = 2'd1,
      ACT_STALL    = 2'd2,
      ACT_LOAD_ADR = 2'd3
   } action_type;

   // Device states
   typedef enum logic [1:0] {
      DEV_DEFAULT    = 2'd0,
      DEV_ADDRESSED  = 2'd1,
      DEV_CONFIGURED = 2'd2
   } dev_state_type;

   // Data sources
   localparam logic [3:0] SRC_STATUS  = 4'd0;
   localparam logic [3:0] SRC_DEVICE  = 4'd1;
   localparam logic [3:0] SRC_CONFIG  = 4'd2;
   localparam logic [3:0] SRC_STRING0 = 4'd3;
   localparam logic [3:0] SRC_STRING1 = 4'd4;
   localparam logic [3:0] SRC_STRING2 = 4'd5;
   localparam logic [3:0] SRC_STRING3 = 4'd6;
   localparam logic [3:0] SRC_HID     = 4'd7;
   localparam logic [3:0] SRC_EMPTY   = 4'd8;

   // Register indexes
   localparam logic [2:0] CSR_EP0_MAX_PACKET = 3'd0;
   localparam logic [2:0] CSR_DEVICE_DESC    = 3'd1;
   localparam logic [2:0] CSR_CONFIG_TOTAL   = 3'd2;
   localparam logic [2:0] CSR_LANG_STRING    = 3'd3;
   localparam logic [2:0] CSR_MAKER_STRING   = 3'd4;
   localparam logic [2:0] CSR_PRODUCT_STRING = 3'd5;
   localparam logic [2:0] CSR_SERIAL_STRING  = 3'd6;
   localparam logic [2:0] CSR_HID_REPORT     = 3'd7;

   // Request codes
   localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
   localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
   localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
   localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
   localparam logic [7:0] REQ_SET_IDLE       = 8'h0A;

   // bmRequestType values and type field
   localparam logic [7:0] RT_TYPE_MASK = 8'h60;
   localparam logic [7:0] RT_STANDARD  = 8'h00;
   localparam logic [7:0] RT_CLASS     = 8'h20;
   localparam logic [7:0] RT_HOST_OUT  = 8'h00;
   localparam logic [7:0] RT_DEV_IN    = 8'h80;
   localparam logic [7:0] RT_IF_IN     = 8'h81;

   // Descriptor kinds in the high byte of wValue
   localparam logic [7:0] DESC_DEVICE     = 8'h01;
   localparam logic [7:0] DESC_CONFIG     = 8'h02;
   localparam logic [7:0] DESC_STRING     = 8'h03;
   localparam logic [7:0] DESC_QUALIFIER  = 8'h06;
   localparam logic [7:0] DESC_HID_REPORT = 8'h22;

   // Max packet clamp limits
   localparam logic [6:0] MP_MIN = 7'd8;
   localparam logic [6:0] MP_MAX = 7'd64;

   typedef struct packed {
      logic [6:0]  ep0_max_packet;
      logic [7:0]  device_desc_len;
      logic [15:0] config_total_len;
      logic [7:0]  lang_string_len;
      logic [7:0]  maker_string_len;
      logic [7:0]  product_string_len;
      logic [7:0]  serial_string_len;
      logic [15:0] hid_report_len;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_index;
      logic [15:0] request_length;
      logic        app_accepts;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  data_source;
      logic [15:0] data_offset;
      logic [6:0]  packet_bytes;
      logic        rearm_out;
      logic [6:0]  address_out;
      logic [1:0]  device_state;
      logic        suspended;
      logic        idle_strobe;
      logic [15:0] idle_interface;
      logic [15:0] idle_value;
   } rsp_type;

endpackage

FILE: design/usb_control_endpoint_engine.sv
`timescale 1ns / 1ps
// A request word is captured in the request register and moves on to the result
// register, raising rsp_tvalid, once that register is free or drains.
// Throughput: one word per cycle while the result side is not stalled; the decode
// and packet sizing between the two registers are combinational.
// Reset: synchronous, active high; device state default, no transfer, not
// suspended, and the configuration registers back at their default values.

module usb_control_endpoint_engine
   import usbcep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: request_type[7:0], request_code[15:8], request_value[31:16],
   //        request_index[47:32], request_length[63:48], app_accepts[64], zero pad
   input  logic [71:0] req_tdata,
   // tuser: cmd[2:0]
   input  logic [2:0]  req_tuser,
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: data_source[3:0], data_offset[19:4], packet_bytes[26:20],
   //        rearm_out[27], address_out[34:28], device_state[36:35],
   //        suspended[37], idle_strobe[38], idle_interface[54:39],
   //        idle_value[70:55], zero pad
   output logic [71:0] rsp_tdata,
   // tuser: action[1:0]
   output logic [1:0]  rsp_tuser,
   // Configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_word_ff;
   rsp_type core_rsp;
   cfg_type cfg;
   logic    fire;
   logic    take;

   usbcep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   usbcep_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_word_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   // Move a word forward when the result register is free or drains
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (take) begin
         in_word_ff.cmd            <= req_tuser;
         in_word_ff.request_type   <= req_tdata[7:0];
         in_word_ff.request_code   <= req_tdata[15:8];
         in_word_ff.request_value  <= req_tdata[31:16];
         in_word_ff.request_index  <= req_tdata[47:32];
         in_word_ff.request_length <= req_tdata[63:48];
         in_word_ff.app_accepts    <= req_tdata[64];
      end
   end

   // Hold the result word
   always_ff @(posedge clock) begin
      if (fire) begin
         out_word_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_word_ff.action;
   assign rsp_tdata  = {1'b0,
                        out_word_ff.idle_value,
                        out_word_ff.idle_interface,
                        out_word_ff.idle_strobe,
                        out_word_ff.suspended,
                        out_word_ff.device_state,
                        out_word_ff.address_out,
                        out_word_ff.rearm_out,
                        out_word_ff.packet_bytes,
                        out_word_ff.data_offset,
                        out_word_ff.data_source};

   // A word taken by the core shows on the result side next cycle
   a_fire_shows : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("decoded word did not reach the result register");

   // Packet fields stay zero unless an IN packet is sent
   a_pkt_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ACT_SEND_IN) |->
         (rsp_tdata[27:4] == 24'd0 && rsp_tdata[3:0] == 4'd0))
      else $error("packet fields set without an IN packet");

   // A packet never exceeds the largest endpoint 0 size
   a_pkt_size : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[26:20] <= MP_MAX)
      else $error("packet larger than max packet size");

   // Address is only driven on a load-address result
   a_addr_only : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ACT_LOAD_ADR) |-> rsp_tdata[34:28] == 7'd0)
      else $error("address driven without a load action");

   // A packet shorter than the smallest endpoint 0 size always ends the transfer
   a_short_rearm : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ACT_SEND_IN && rsp_tdata[26:20] < MP_MIN) |->
         rsp_tdata[27])
      else $error("short packet did not end the transfer");

endmodule

FILE: design/usbcep_csr.sv
`timescale 1ns / 1ps

module usbcep_csr
   import usbcep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EP0_MAX_PACKET: cfg_in.ep0_max_packet     = csr_wdata[6:0];
            CSR_DEVICE_DESC:    cfg_in.device_desc_len    = csr_wdata[7:0];
            CSR_CONFIG_TOTAL:   cfg_in.config_total_len   = csr_wdata;
            CSR_LANG_STRING:    cfg_in.lang_string_len    = csr_wdata[7:0];
            CSR_MAKER_STRING:   cfg_in.maker_string_len   = csr_wdata[7:0];
            CSR_PRODUCT_STRING: cfg_in.product_string_len = csr_wdata[7:0];
            CSR_SERIAL_STRING:  cfg_in.serial_string_len  = csr_wdata[7:0];
            CSR_HID_REPORT:     cfg_in.hid_report_len     = csr_wdata;
         endcase
      end
   end

   // Hold the registers, load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ep0_max_packet     <= 7'd64;
         cfg_ff.device_desc_len    <= 8'd18;
         cfg_ff.config_total_len   <= 16'd34;
         cfg_ff.lang_string_len    <= 8'd4;
         cfg_ff.maker_string_len   <= 8'd0;
         cfg_ff.product_string_len <= 8'd0;
         cfg_ff.serial_string_len  <= 8'd0;
         cfg_ff.hid_report_len     <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/usbcep_core.sv
`timescale 1ns / 1ps

module usbcep_core
   import usbcep_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic [1:0]  dev_state_ff, dev_state_in;
   logic        suspend_ff, suspend_in;
   logic [6:0]  pend_addr_ff, pend_addr_in;
   logic [7:0]  last_req_ff, last_req_in;
   logic        active_ff, active_in;
   logic [3:0]  src_ff, src_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] off_ff, off_in;

   logic        start_go;
   logic [3:0]  start_src;
   logic [15:0] start_len;
   logic        stall;
   logic        idle_hit;
   logic [15:0] idle_if;
   logic [15:0] idle_val;
   logic        do_pkt;
   logic [15:0] pk_off;
   logic [15:0] pk_len;
   logic [3:0]  pk_src;
   logic [16:0] rem_diff;
   logic [15:0] rem;
   logic [6:0]  mp;
   logic [6:0]  nbytes;
   logic        last_pkt;
   logic [7:0]  rtype;
   logic [7:0]  kind;
   logic [7:0]  str_idx;
   logic        is_setup;

   assign rtype    = req.request_type;
   assign kind     = req.request_value[15:8];
   assign str_idx  = req.request_value[7:0];
   assign is_setup = (req.cmd == CMD_SETUP);

   // Clamp the max packet size into the legal range
   always_comb begin
      if (cfg.ep0_max_packet < MP_MIN) begin
         mp = MP_MIN;
      end else if (cfg.ep0_max_packet > MP_MAX) begin
         mp = MP_MAX;
      end else begin
         mp = cfg.ep0_max_packet;
      end
   end

   // Decode setup and bus reset into state, start or stall
   always_comb begin
      start_go     = 1'b0;
      start_src    = SRC_EMPTY;
      start_len    = 16'd0;
      stall        = 1'b0;
      dev_state_in = dev_state_ff;
      pend_addr_in = pend_addr_ff;
      idle_hit     = 1'b0;
      idle_if      = 16'd0;
      idle_val     = 16'd0;
      if (is_setup) begin
         if ((rtype & RT_TYPE_MASK) == RT_STANDARD) begin
            priority if (req.request_code == REQ_GET_STATUS) begin
               if (rtype == RT_DEV_IN && req.request_length == 16'd2 && !active_ff) begin
                  start_go  = 1'b1;
                  start_src = SRC_STATUS;
                  start_len = 16'd2;
               end
            end else if (req.request_code == REQ_SET_ADDRESS) begin
               if (rtype == RT_HOST_OUT && dev_state_ff != DEV_CONFIGURED) begin
                  pend_addr_in = req.request_value[6:0];
                  dev_state_in = (req.request_value != 16'd0) ? DEV_ADDRESSED : DEV_DEFAULT;
                  start_go     = 1'b1;
               end
            end else if (req.request_code == REQ_GET_DESCRIPTOR) begin
               if (rtype == RT_DEV_IN) begin
                  priority if (kind == DESC_DEVICE) begin
                     start_go  = 1'b1;
                     start_src = SRC_DEVICE;
                     start_len = {8'd0, cfg.device_desc_len};
                  end else if (kind == DESC_CONFIG) begin
                     start_go  = 1'b1;
                     start_src = SRC_CONFIG;
                     start_len = (req.request_length < cfg.config_total_len) ?
                                 req.request_length : cfg.config_total_len;
                  end else if (kind == DESC_STRING) begin
                     priority if (str_idx == 8'd0) begin
                        start_go  = 1'b1;
                        start_src = SRC_STRING0;
                        start_len = {8'd0, cfg.lang_string_len};
                     end else if (str_idx == 8'd1) begin
                        start_go  = 1'b1;
                        start_src = SRC_STRING1;
                        start_len = {8'd0, cfg.maker_string_len};
                     end else if (str_idx == 8'd2) begin
                        start_go  = 1'b1;
                        start_src = SRC_STRING2;
                        start_len = {8'd0, cfg.product_string_len};
                     end else if (str_idx == 8'd3) begin
                        start_go  = 1'b1;
                        start_src = SRC_STRING3;
                        start_len = {8'd0, cfg.serial_string_len};
                     end else begin
                        start_go  = 1'b0;
                     end
                  end else if (kind == DESC_QUALIFIER) begin
                     stall = 1'b1;
                  end else begin
                     start_go = 1'b0;
                  end
               end else if (rtype == RT_IF_IN) begin
                  if (kind == DESC_HID_REPORT) begin
                     start_go  = 1'b1;
                     start_src = SRC_HID;
                     start_len = cfg.hid_report_len;
                  end
               end
            end else if (req.request_code == REQ_SET_CONFIG) begin
               if (rtype == RT_HOST_OUT && dev_state_ff != DEV_DEFAULT && req.app_accepts) begin
                  dev_state_in = DEV_CONFIGURED;
                  start_go     = 1'b1;
               end else begin
                  stall = 1'b1;
               end
            end else begin
               start_go = 1'b0;
            end
         end else if ((rtype & RT_TYPE_MASK) == RT_CLASS) begin
            if (req.request_code == REQ_SET_IDLE) begin
               idle_hit = 1'b1;
               idle_if  = req.request_index;
               idle_val = req.request_value;
               start_go = 1'b1;
            end
         end
      end else if (req.cmd == CMD_BUS_RST) begin
         dev_state_in = DEV_DEFAULT;
         pend_addr_in = 7'd0;
      end
   end

   // Size the next packet from a new transfer or the one in flight
   assign do_pkt   = start_go || (req.cmd == CMD_IN_DONE && active_ff);
   assign pk_off   = start_go ? 16'd0 : off_ff;
   assign pk_len   = start_go ? start_len : len_ff;
   assign pk_src   = start_go ? start_src : src_ff;
   assign rem_diff = {1'b0, pk_len} - {1'b0, pk_off};
   assign rem      = (pk_off <= pk_len) ? rem_diff[15:0] : 16'd0;
   assign nbytes   = (rem > {9'd0, mp}) ? mp : rem[6:0];
   assign last_pkt = (nbytes < mp);

   // Advance transfer, suspend and request state
   always_comb begin
      active_in   = active_ff;
      src_in      = src_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      suspend_in  = suspend_ff;
      last_req_in = last_req_ff;
      if (is_setup) begin
         last_req_in = req.request_code;
      end
      if (start_go) begin
         src_in = start_src;
         len_in = start_len;
      end
      if (do_pkt) begin
         active_in = !last_pkt;
         off_in    = pk_off + {9'd0, nbytes};
      end
      unique case (req.cmd)
         CMD_BUS_RST: active_in  = 1'b0;
         CMD_SUSPEND: suspend_in = 1'b1;
         CMD_WAKEUP:  suspend_in = 1'b0;
         default:     suspend_in = suspend_ff;
      endcase
   end

   // Build the result word
   always_comb begin
      rsp.action       = ACT_NONE;
      rsp.data_source  = 4'd0;
      rsp.data_offset  = 16'd0;
      rsp.packet_bytes = 7'd0;
      rsp.rearm_out    = 1'b0;
      rsp.address_out  = 7'd0;
      if (do_pkt) begin
         rsp.action       = ACT_SEND_IN;
         rsp.data_source  = pk_src;
         rsp.data_offset  = pk_off;
         rsp.packet_bytes = nbytes;
         rsp.rearm_out    = last_pkt;
      end else if (stall) begin
         rsp.action = ACT_STALL;
      end else if (req.cmd == CMD_IN_DONE && last_req_ff == REQ_SET_ADDRESS) begin
         rsp.action      = ACT_LOAD_ADR;
         rsp.address_out = pend_addr_ff;
      end
      rsp.device_state   = dev_state_in;
      rsp.suspended      = suspend_in;
      rsp.idle_strobe    = idle_hit;
      rsp.idle_interface = idle_if;
      rsp.idle_value     = idle_val;
   end

   // Commit state when the word moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_state_ff <= DEV_DEFAULT;
         suspend_ff   <= 1'b0;
         pend_addr_ff <= 7'd0;
         last_req_ff  <= 8'd0;
         active_ff    <= 1'b0;
         src_ff       <= 4'd0;
         len_ff       <= 16'd0;
         off_ff       <= 16'd0;
      end else if (fire) begin
         dev_state_ff <= dev_state_in;
         suspend_ff   <= suspend_in;
         pend_addr_ff <= pend_addr_in;
         last_req_ff  <= last_req_in;
         active_ff    <= active_in;
         src_ff       <= src_in;
         len_ff       <= len_in;
         off_ff       <= off_in;
      end
   end

endmodule
